// ===== rtl/idl_token_scanner_assert.svh =====
// Assertion macros for the token scanner.
`ifndef IDL_TOKEN_SCANNER_ASSERT_SVH
`define IDL_TOKEN_SCANNER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ITS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ITS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/its_pkg.sv =====
package its_pkg;

  localparam int unsigned LenBits  = 8;
  localparam int unsigned PosBits  = 32;
  localparam int unsigned LineBits = 16;
  localparam int unsigned NKeys    = 21;
  localparam int unsigned KeyChars = 8;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = 2;

  localparam logic [5:0] KindEof   = 6'd0;
  localparam logic [5:0] KindConst = 6'd12;
  localparam logic [5:0] KindIdent = 6'd13;
  localparam logic [5:0] KindKey0  = 6'd14;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrIllegal = 2'd1;
  localparam logic [1:0] ErrUnterm  = 2'd2;

  typedef enum logic [7:0] {
    ModeIdle = 8'b0000_0001,
    ModeIdent = 8'b0000_0010,
    ModeConst = 8'b0000_0100,
    ModeSlash = 8'b0000_1000,
    ModeComment = 8'b0001_0000,
    ModeDirective = 8'b0010_0000,
    ModeDone = 8'b0100_0000,
    ModeHalt = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic                func;
    logic [7:0]          ch;
  } in_word_t;

  typedef struct packed {
    logic [5:0]          token_kind;
    logic [1:0]          error_code;
    logic [PosBits-1:0]  token_start;
    logic [LenBits-1:0]  token_length;
    logic [LineBits-1:0] line_number;
    logic [7:0]          bad_char;
    logic                last;
  } out_word_t;

  // one classified step: up to two results
  typedef struct packed {
    logic      has0;
    out_word_t res0;
    logic      has1;
    out_word_t res1;
  } step_t;

  function automatic logic [7:0] key_char(input int unsigned k, input int unsigned p);
    string s;
    begin
      case (k)
        0: s = "union";     1: s = "switch";  2: s = "case";    3: s = "default";
        4: s = "struct";    5: s = "typedef"; 6: s = "enum";    7: s = "array";
        8: s = "opaque";    9: s = "bool";    10: s = "void";   11: s = "char";
        12: s = "int";      13: s = "unsigned"; 14: s = "short"; 15: s = "long";
        16: s = "float";    17: s = "double"; 18: s = "string"; 19: s = "program";
        default: s = "version";
      endcase
      key_char = (p < s.len()) ? s[p] : 8'd0;
    end
  endfunction

  function automatic logic [3:0] key_len(input int unsigned k);
    logic [3:0] t;
    begin
      t = 4'd0;
      for (int unsigned p = 0; p < KeyChars; p++) begin
        if (key_char(k, p) != 8'd0) t = 4'(p + 1);
      end
      key_len = t;
    end
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h3A: punct_kind = 4'd1;  8'h3B: punct_kind = 4'd2;  8'h2C: punct_kind = 4'd3;
      8'h3D: punct_kind = 4'd4;  8'h2A: punct_kind = 4'd5;  8'h5B: punct_kind = 4'd6;
      8'h5D: punct_kind = 4'd7;  8'h7B: punct_kind = 4'd8;  8'h7D: punct_kind = 4'd9;
      8'h28: punct_kind = 4'd10; 8'h29: punct_kind = 4'd11;
      default: punct_kind = 4'd0;
    endcase
  endfunction

endpackage

// ===== rtl/its_stream_if.sv =====
interface its_in_if;
  logic              valid;
  logic              ready;
  its_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface its_out_if;
  logic               valid;
  logic               ready;
  its_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/its_front.sv =====
module its_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  its_pkg::in_word_t in_data_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            push_o,
  output its_pkg::step_t  step_o
);
  localparam logic [its_pkg::LenBits-1:0] LenMax = '1;
  localparam logic [its_pkg::LineBits-1:0] LineMax = '1;

  its_pkg::mode_e                mode_q, mode_d;
  logic [its_pkg::NKeys-1:0]     cand_q, cand_d;
  logic [its_pkg::LenBits-1:0]   plen_q, plen_d;
  logic [its_pkg::PosBits-1:0]   pstart_q, pstart_d;
  logic [its_pkg::LineBits-1:0]  pline_q, pline_d;
  logic [its_pkg::PosBits-1:0]   off_q;
  logic [its_pkg::LineBits-1:0]  line_q;
  logic                          lstart_q, dco_q, dco_d;
  logic [7:0]                    prev_q, prev_d;
  logic                          acc;
  logic [7:0]                    c;
  logic                          is_sp, is_dig, is_al, is_wd, nl;
  logic [5:0]                    flush_kind;
  its_pkg::step_t                st;

  function automatic its_pkg::out_word_t mk(input logic [5:0] k, input logic [1:0] e,
      input logic [its_pkg::PosBits-1:0] s, input logic [its_pkg::LenBits-1:0] l,
      input logic [its_pkg::LineBits-1:0] ln, input logic [7:0] b);
    its_pkg::out_word_t w;
    begin
      w.token_kind = k; w.error_code = e; w.token_start = s; w.token_length = l;
      w.line_number = ln; w.bad_char = b; w.last = 1'b0;
      mk = w;
    end
  endfunction

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;
  assign c = in_data_i.ch;
  assign is_sp = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  assign is_dig = c >= 8'h30 && c <= 8'h39;
  assign is_al = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_wd = is_al || is_dig || c == 8'h5F;
  assign nl = c == 8'h0A;

  always_comb begin
    flush_kind = (mode_q == its_pkg::ModeIdent) ? its_pkg::KindIdent : its_pkg::KindConst;
    if (mode_q == its_pkg::ModeIdent) begin
      for (int unsigned k = 0; k < its_pkg::NKeys; k++) begin
        if (cand_q[k] && plen_q == its_pkg::LenBits'(its_pkg::key_len(k)))
          flush_kind = its_pkg::KindKey0 + 6'(k);
      end
    end
  end

  always_comb begin
    logic idle_path;
    logic [3:0] pk;
    mode_d = mode_q; cand_d = cand_q; plen_d = plen_q; pstart_d = pstart_q;
    pline_d = pline_q; dco_d = dco_q; prev_d = prev_q;
    st = '0;
    idle_path = 1'b0;
    pk = its_pkg::punct_kind(c);
    if (mode_q == its_pkg::ModeDone) begin
      st.has0 = 1'b1;
      st.res0 = mk(its_pkg::KindEof, its_pkg::ErrNone, off_q, '0, line_q, 8'd0);
    end else if (in_data_i.func) begin
      unique case (mode_q)
        its_pkg::ModeIdent, its_pkg::ModeConst: begin
          st.has0 = 1'b1;
          st.res0 = mk(flush_kind, its_pkg::ErrNone, pstart_q, plen_q, pline_q, 8'd0);
          st.has1 = 1'b1;
          st.res1 = mk(its_pkg::KindEof, its_pkg::ErrNone, off_q, '0, line_q, 8'd0);
          mode_d = its_pkg::ModeDone; cand_d = '0;
        end
        its_pkg::ModeSlash: begin
          st.has0 = 1'b1;
          st.res0 = mk(its_pkg::KindEof, its_pkg::ErrIllegal, pstart_q, '0, pline_q, 8'h2F);
          mode_d = its_pkg::ModeHalt;
        end
        its_pkg::ModeComment: begin
          st.has0 = 1'b1;
          st.res0 = mk(its_pkg::KindEof, its_pkg::ErrUnterm, off_q, '0, line_q, 8'd0);
          mode_d = its_pkg::ModeHalt;
        end
        its_pkg::ModeDirective: begin
          st.has0 = 1'b1;
          st.res0 = mk(its_pkg::KindEof, dco_q ? its_pkg::ErrUnterm : its_pkg::ErrNone,
                       off_q, '0, line_q, 8'd0);
          mode_d = dco_q ? its_pkg::ModeHalt : its_pkg::ModeDone;
        end
        default: begin
          st.has0 = 1'b1;
          st.res0 = mk(its_pkg::KindEof, its_pkg::ErrNone, off_q, '0, line_q, 8'd0);
          mode_d = its_pkg::ModeDone;
        end
      endcase
    end else begin
      unique case (mode_q)
        its_pkg::ModeComment: begin
          if (prev_q == 8'h2A && c == 8'h2F) begin
            mode_d = its_pkg::ModeIdle; prev_d = 8'd0;
          end else prev_d = c;
        end
        its_pkg::ModeDirective: begin
          if (nl) begin
            mode_d = dco_q ? its_pkg::ModeComment : its_pkg::ModeIdle;
            dco_d = 1'b0; prev_d = 8'd0;
          end else begin
            if (prev_q == 8'h2F && c == 8'h2A) dco_d = 1'b1;
            if (prev_q == 8'h2A && c == 8'h2F) dco_d = 1'b0;
            prev_d = c;
          end
        end
        its_pkg::ModeSlash: begin
          if (c == 8'h2A) begin
            mode_d = its_pkg::ModeComment; prev_d = 8'd0;
          end else begin
            st.has0 = 1'b1;
            st.res0 = mk(its_pkg::KindEof, its_pkg::ErrIllegal, pstart_q, '0, pline_q, 8'h2F);
            mode_d = its_pkg::ModeHalt;
          end
        end
        its_pkg::ModeIdent: begin
          if (is_wd) begin
            for (int unsigned k = 0; k < its_pkg::NKeys; k++) begin
              if (cand_q[k] && (plen_q >= its_pkg::LenBits'(its_pkg::key_len(k)) ||
                  its_pkg::key_char(k, 32'(plen_q[3:0])) != c))
                cand_d[k] = 1'b0;
            end
            plen_d = (plen_q == LenMax) ? LenMax : plen_q + 1'b1;
          end else begin
            st.has0 = 1'b1;
            st.res0 = mk(flush_kind, its_pkg::ErrNone, pstart_q, plen_q, pline_q, 8'd0);
            cand_d = '0; mode_d = its_pkg::ModeIdle;
            idle_path = 1'b1;
          end
        end
        its_pkg::ModeConst: begin
          if (is_dig) begin
            plen_d = (plen_q == LenMax) ? LenMax : plen_q + 1'b1;
          end else begin
            st.has0 = 1'b1;
            st.res0 = mk(flush_kind, its_pkg::ErrNone, pstart_q, plen_q, pline_q, 8'd0);
            cand_d = '0; mode_d = its_pkg::ModeIdle;
            idle_path = 1'b1;
          end
        end
        default: idle_path = 1'b1;
      endcase
      if (idle_path && !is_sp) begin
        its_pkg::out_word_t r;
        logic emit_r;
        r = '0; emit_r = 1'b0;
        if (pk != 4'd0) begin
          emit_r = 1'b1;
          r = mk({2'b00, pk}, its_pkg::ErrNone, off_q, its_pkg::LenBits'(1), line_q, 8'd0);
        end else if (c == 8'h2F) begin
          mode_d = its_pkg::ModeSlash; pstart_d = off_q; pline_d = line_q;
        end else if (c == 8'h23 && lstart_q) begin
          mode_d = its_pkg::ModeDirective; dco_d = 1'b0; prev_d = c;
        end else if (is_dig || is_al || c == 8'h5F) begin
          mode_d = is_dig ? its_pkg::ModeConst : its_pkg::ModeIdent;
          pstart_d = off_q; pline_d = line_q; plen_d = its_pkg::LenBits'(1);
          cand_d = '0;
          if (!is_dig) begin
            for (int unsigned k = 0; k < its_pkg::NKeys; k++)
              cand_d[k] = its_pkg::key_char(k, 0) == c;
          end
        end else begin
          emit_r = 1'b1;
          r = mk(its_pkg::KindEof, its_pkg::ErrIllegal, off_q, '0, line_q, c);
          mode_d = its_pkg::ModeHalt;
        end
        if (emit_r) begin
          if (st.has0) begin
            st.has1 = 1'b1; st.res1 = r;
          end else begin
            st.has0 = 1'b1; st.res0 = r;
          end
        end
      end
    end
    if (st.has1) st.res1.last = 1'b1;
    else st.res0.last = 1'b1;
  end

  assign push_o = acc && mode_q != its_pkg::ModeHalt && st.has0;
  assign step_o = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= its_pkg::ModeIdle; cand_q <= '0; plen_q <= '0; pstart_q <= '0;
      pline_q <= its_pkg::LineBits'(1); off_q <= '0; line_q <= its_pkg::LineBits'(1);
      lstart_q <= 1'b1; dco_q <= 1'b0; prev_q <= 8'd0;
    end else if (acc && mode_q != its_pkg::ModeHalt && mode_q != its_pkg::ModeDone) begin
      mode_q <= mode_d; cand_q <= cand_d; plen_q <= plen_d; pstart_q <= pstart_d;
      pline_q <= pline_d; dco_q <= dco_d; prev_q <= prev_d;
      if (!in_data_i.func) begin
        lstart_q <= nl;
        if (nl && line_q != LineMax) line_q <= line_q + 1'b1;
        off_q <= off_q + 1'b1;
      end
    end
  end
endmodule

// ===== rtl/its_back.sv =====
`include "idl_token_scanner_assert.svh"
module its_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  its_pkg::step_t step_i,
  output logic           full_o,
  its_out_if.source      out
);
  logic [its_pkg::QPtrBits-1:0] wr_q, rd_q;
  logic [its_pkg::QPtrBits:0]   cnt_q;
  its_pkg::out_word_t           mem_q [its_pkg::QDepth];
  logic                         pop;

  assign full_o = cnt_q > (its_pkg::QPtrBits + 1)'(its_pkg::QDepth - 2);
  assign out.valid = cnt_q != '0;
  assign out.data = mem_q[rd_q];
  assign pop = out.valid && out.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= step_i.res0;
      if (step_i.has1) mem_q[wr_q + 1'b1] <= step_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + (step_i.has1 ? 2'd2 : 2'd1);
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? (step_i.has1 ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  `ITS_ASSERT_IMP(a_no_overflow, push_i, cnt_q <= 3'(its_pkg::QDepth - 2))
  `ITS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= 3'(its_pkg::QDepth))
  `ITS_ASSERT_NEXT(a_push_shows, push_i, out.valid)
endmodule

// ===== rtl/idl_token_scanner.sv =====
// A token is written into the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the queue is not full; up to two result words per byte are queued.
// The four-word result queue drains one word per cycle while the output is ready and stalls input when
// fewer than two entries are free.
// Reset (rst_ni low, async): idle, offset 0, line 1; after an error no output.
module idl_token_scanner (
  input logic       clk_i,
  input logic       rst_ni,
  its_in_if.sink    in_if,
  its_out_if.source out_if
);
  logic           full, push;
  its_pkg::step_t step;

  its_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_data_i(in_if.data), .in_ready_o(in_if.ready),
    .q_full_i(full), .push_o(push), .step_o(step)
  );

  its_back u_back (
    .clk_i, .rst_ni, .push_i(push), .step_i(step), .full_o(full), .out(out_if)
  );
endmodule
